// ----- rtl/core/bist_pkg.sv -----
// shared types and constants for the bounded id set table
package bist_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = 4;
	localparam int CNT_W    = 5;
	localparam int ID_W     = 32;

	localparam logic [ID_W-1:0]  NONE_ID = '1;
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	typedef enum logic [1:0] {
		OP_ADD  = 2'd0,
		OP_DEL  = 2'd1,
		OP_FIND = 2'd2,
		OP_READ = 2'd3
	} op_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} st_t;

	// broadcast from the sequencer to every cell
	typedef struct packed {
		logic             capture;
		logic             commit;
		logic             add_ok;
		op_t              kind;
		logic [CNT_W-1:0] count;
		logic [ID_W-1:0]  cap_id;
		logic [ID_W-1:0]  id;
		logic [IDX_W-1:0] index;
		logic [ID_W-1:0]  last;
	} cell_ctrl_t;

endpackage

// ----- rtl/core/bist_cell.sv -----
// one slot of the table with its match flag and link to the next cell
module bist_cell import bist_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cell_ctrl_t       ctrl,
	input  logic [IDX_W-1:0] pos,
	input  logic             hit_in,
	output logic             hit_out,
	output logic             first,
	output logic [ID_W-1:0]  last_part,
	output logic [ID_W-1:0]  read_part
);

	logic [ID_W-1:0] slot_q;
	logic            hit_s1;
	logic            filled;
	logic            is_last;
	logic            is_tail;

	assign filled  = {1'b0, pos} < ctrl.count;
	assign is_last = {1'b0, pos} == (ctrl.count - CNT_W'(1));
	assign is_tail = {1'b0, pos} == ctrl.count;

	// lowest hit wins: a hit from any cell below masks this one
	assign hit_out = hit_in | hit_s1;
	assign first   = hit_s1 & ~hit_in;

	assign last_part = is_last ? slot_q : '0;
	assign read_part = (pos == ctrl.index) ? slot_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= NONE_ID;
			hit_s1 <= 1'b0;
		end else begin
			if (ctrl.capture) begin
				hit_s1 <= filled && (slot_q == ctrl.cap_id) && (ctrl.cap_id != NONE_ID);
			end
			if (ctrl.commit) begin
				if (ctrl.add_ok && is_tail) begin
					slot_q <= ctrl.id;
				end else if (ctrl.kind == OP_DEL && first) begin
					slot_q <= ctrl.last;
				end
			end
		end
	end

endmodule

// ----- rtl/core/bounded_id_set_table_top.sv -----
// top level of the bounded id set table: sequencer, cell row and result register
//
// Input channel (in_valid / in_stall) carries one operation per transaction:
// kind (add, delete, find, read), id and index. Output channel
// (out_valid / out_stall) returns exactly one result per operation:
// status, found, count after the operation and slot_value.
// Each operation runs in two steps: in the accept cycle every cell compares
// its slot against the id and the last and indexed slots are latched; in the
// second step the first-hit flag ripples along the cell row, the add or
// delete write lands in the cells and the result register is loaded.
// The two-step sequencer takes no new operation until the current one has
// finished; in_stall is high during the second step.
// A finished result sits in the output register while the next operation
// is accepted; if the receiver keeps out_stall high, the second step of that
// next operation waits (and in_stall stays high) until the register frees.
// Reset (arst_n low) sets every slot to all ones, the count to zero and
// empties the output register; the block accepts right after reset.
module bounded_id_set_table_top import bist_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [1:0]             kind,
	input  logic signed [ID_W-1:0] id,
	input  logic [IDX_W-1:0]       index,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   status,
	output logic                   found,
	output logic [CNT_W-1:0]       count,
	output logic signed [ID_W-1:0] slot_value
);

	st_t              state_q, state_d;
	logic             accept;
	logic             done;

	op_t              kind_s1;
	logic [ID_W-1:0]  id_s1;
	logic [IDX_W-1:0] index_s1;
	logic [ID_W-1:0]  last_s1;
	logic [ID_W-1:0]  read_s1;
	logic [CNT_W-1:0] cnt_q;

	logic             out_valid_q;
	logic             status_q;
	logic             found_q;
	logic [CNT_W-1:0] count_q;
	logic [ID_W-1:0]  value_q;

	cell_ctrl_t       ctrl;
	logic [CAPACITY:0]   hit_chain;
	logic [CAPACITY-1:0] first_vec;
	logic [ID_W-1:0]     last_parts [CAPACITY];
	logic [ID_W-1:0]     read_parts [CAPACITY];
	logic [ID_W-1:0]     last_bus;
	logic [ID_W-1:0]     read_bus;

	logic             add_ok;
	logic             hit_any;
	logic             res_status;
	logic             res_found;
	logic [CNT_W-1:0] res_count;
	logic [ID_W-1:0]  res_value;

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (done) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		accept   = 1'b0;
		done     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				accept   = in_valid;
			end
			ST_EXEC: begin
				done = ~out_valid_q | ~out_stall;
			end
			default: in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= op_t'(kind);
			id_s1    <= id;
			index_s1 <= index;
			last_s1  <= last_bus;
			read_s1  <= read_bus;
		end
	end

	assign add_ok = (kind_s1 == OP_ADD) && (id_s1 != NONE_ID) && (cnt_q < CAP_CNT);

	always_comb begin
		ctrl.capture = accept;
		ctrl.commit  = done;
		ctrl.add_ok  = add_ok;
		ctrl.kind    = kind_s1;
		ctrl.count   = cnt_q;
		ctrl.cap_id  = id;
		ctrl.id      = id_s1;
		ctrl.index   = index;
		ctrl.last    = last_s1;
	end

	// cell row
	assign hit_chain[0] = 1'b0;

	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		bist_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.pos       (IDX_W'(k)),
			.hit_in    (hit_chain[k]),
			.hit_out   (hit_chain[k+1]),
			.first     (first_vec[k]),
			.last_part (last_parts[k]),
			.read_part (read_parts[k])
		);
	end

	always_comb begin
		last_bus = '0;
		read_bus = '0;
		for (int k = 0; k < CAPACITY; k++) begin
			last_bus = last_bus | last_parts[k];
			read_bus = read_bus | read_parts[k];
		end
	end

	assign hit_any = hit_chain[CAPACITY];

	always_comb begin
		res_status = 1'b0;
		res_found  = 1'b0;
		res_count  = cnt_q;
		res_value  = NONE_ID;
		case (kind_s1)
			OP_ADD: begin
				res_status = ~add_ok;
				if (add_ok) res_count = cnt_q + CNT_W'(1);
			end
			OP_DEL: begin
				res_status = ~hit_any;
				if (hit_any) res_count = cnt_q - CNT_W'(1);
			end
			OP_FIND: begin
				res_found = hit_any;
			end
			default: begin
				if ({1'b0, index_s1} < CAP_CNT) begin
					res_value = read_s1;
				end else begin
					res_status = 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (done) begin
				cnt_q       <= res_count;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			status_q <= res_status;
			found_q  <= res_found;
			count_q  <= res_count;
			value_q  <= res_value;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign found      = found_q;
	assign count      = count_q;
	assign slot_value = value_q;

	// checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CAP_CNT)
		else $error("fill count above capacity");

	a_first_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EXEC |-> $onehot0(first_vec))
		else $error("more than one first hit in the cell row");

	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!done |=> $stable(cnt_q))
		else $error("fill count changed outside a commit");

	a_out_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !done) |=> !out_valid)
		else $error("result register not emptied after transaction");

endmodule
